// ===== design/assert_macros.svh =====
// Assertion macros used by the classifier core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Concurrent assertion sampled on the clock and disabled while reset is low.
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Concurrent assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== design/ucls_pkg.sv =====
// Types, constants and the byte class function of the UTF-8/ASCII classifier.
package ucls_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CLASS_W   = 4;
    localparam int unsigned VERDICT_W = 2;
    localparam int unsigned PEND_W    = 2;

    // Byte classes: sequence length for a lead byte, a marker for continuations.
    localparam logic [CLASS_W-1:0] CLASS_ASCII = 4'd0;
    localparam logic [CLASS_W-1:0] CLASS_LEN2  = 4'd2;
    localparam logic [CLASS_W-1:0] CLASS_LEN3  = 4'd3;
    localparam logic [CLASS_W-1:0] CLASS_LEN4  = 4'd4;
    localparam logic [CLASS_W-1:0] CLASS_BAD   = 4'd8;
    localparam logic [CLASS_W-1:0] CONT_MARK   = 4'd9;
    localparam int unsigned        LEAD_BAD_BIT = 3;

    // Lead class of bytes 0xF0-0xFF, indexed by the low nibble.
    localparam logic [CLASS_W-1:0] TOP_ROW [16] = '{
        CLASS_LEN4, CLASS_LEN4, CLASS_LEN4, CLASS_LEN4, CLASS_LEN4,
        CLASS_BAD,  CLASS_BAD,  CLASS_BAD,  CLASS_BAD,  CLASS_BAD,
        CLASS_BAD,  CLASS_BAD,  CLASS_BAD,  CLASS_BAD,  CLASS_BAD,
        CLASS_BAD
    };

    localparam logic [VERDICT_W-1:0] VERDICT_INVALID = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_ASCII   = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_UTF8    = 2'd2;

    localparam logic ZERO_INVALID_RESET = 1'b1;

    // One accepted byte request as it moves from the input register to the core.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_byte_req;

    function automatic logic [CLASS_W-1:0] byte_class(input logic [BYTE_W-1:0] b);
        logic [CLASS_W-1:0] cls;
        if (b < 8'h80) begin
            cls = CLASS_ASCII;
        end else if (b < 8'hC0) begin
            cls = CONT_MARK;
        end else if (b < 8'hE0) begin
            cls = CLASS_LEN2;
        end else if (b < 8'hF0) begin
            cls = CLASS_LEN3;
        end else begin
            cls = TOP_ROW[b[3:0]];
        end
        return cls;
    endfunction

endpackage

// ===== design/ucls_byte_if.sv =====
// Valid/ready channel that carries one buffer byte per request.
interface ucls_byte_if;
    logic                          valid;
    logic                          ready;
    logic [ucls_pkg::BYTE_W-1:0]   data_byte;
    logic                          last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== design/ucls_verdict_if.sv =====
// Valid/ready channel that carries one buffer verdict per request.
interface ucls_verdict_if;
    logic                           valid;
    logic                           ready;
    logic [ucls_pkg::VERDICT_W-1:0] verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

// ===== design/ucls_in_reg.sv =====
// Input register stage: captures byte requests and stalls with the core.
module ucls_in_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ucls_byte_if.sink            i_byte,
    input  logic                 i_advance,
    output ucls_pkg::t_byte_req  o_req
);

    logic                          r_valid;
    logic [ucls_pkg::BYTE_W-1:0]   r_data_byte;
    logic                          r_last_byte;
    logic                          w_ready;

    // The register is free when empty or when the core takes its request now.
    assign w_ready      = !r_valid || i_advance;
    assign i_byte.ready = w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_byte.valid) begin
            r_data_byte <= i_byte.data_byte;
            r_last_byte <= i_byte.last_byte;
        end
    end

    assign o_req.valid     = r_valid;
    assign o_req.data_byte = r_data_byte;
    assign o_req.last_byte = r_last_byte;

endmodule

// ===== design/ucls_core.sv =====
// Scan state, per-byte decode and the registered verdict of the classifier.
`include "assert_macros.svh"

module ucls_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic                             i_cfg_wr_data,
    input  ucls_pkg::t_byte_req              i_req,
    input  logic                             i_out_ready,
    output logic                             o_advance,
    output logic                             o_res_valid,
    output logic [ucls_pkg::VERDICT_W-1:0]   o_verdict
);

    typedef enum logic [1:0] {
        ST_SCAN = 2'd0,
        ST_STOP = 2'd1,
        ST_ERR  = 2'd2
    } t_scan_status;

    logic                             r_zero_invalid;
    logic [ucls_pkg::PEND_W-1:0]      r_pend;
    logic                             r_seen;
    t_scan_status                     r_status;
    logic                             r_res_valid;
    logic [ucls_pkg::VERDICT_W-1:0]   r_verdict;

    logic [ucls_pkg::PEND_W-1:0]      n_pend;
    logic                             n_seen;
    t_scan_status                     n_status;
    logic [ucls_pkg::VERDICT_W-1:0]   n_verdict;
    logic [ucls_pkg::CLASS_W-1:0]     w_class;
    logic [ucls_pkg::CLASS_W-1:0]     w_class_m1;
    logic                             w_fire;

    // The whole pipe moves unless a finished verdict is waiting on the receiver.
    assign o_advance  = !r_res_valid || i_out_ready;
    assign w_fire     = i_req.valid && o_advance;
    assign w_class    = ucls_pkg::byte_class(i_req.data_byte);
    assign w_class_m1 = w_class - 4'd1;

    always_comb begin
        n_pend   = r_pend;
        n_seen   = r_seen;
        n_status = r_status;
        if (r_status == ST_SCAN) begin
            if (r_pend != '0) begin
                if (w_class != ucls_pkg::CONT_MARK) begin
                    n_status = ST_ERR;
                end else begin
                    n_pend = r_pend - 2'd1;
                end
            end else if (i_req.data_byte == '0) begin
                n_status = (!i_req.last_byte && r_zero_invalid) ? ST_ERR : ST_STOP;
            end else if (w_class[ucls_pkg::LEAD_BAD_BIT]) begin
                // Continuation bytes and bad leads both carry the bad-lead bit.
                n_status = ST_ERR;
            end else if (w_class != ucls_pkg::CLASS_ASCII) begin
                n_seen = 1'b1;
                n_pend = w_class_m1[ucls_pkg::PEND_W-1:0];
            end
        end
    end

    always_comb begin
        unique case (n_status)
            ST_SCAN, ST_STOP: begin
                if (n_pend != '0) begin
                    n_verdict = ucls_pkg::VERDICT_INVALID;
                end else if (n_seen) begin
                    n_verdict = ucls_pkg::VERDICT_UTF8;
                end else begin
                    n_verdict = ucls_pkg::VERDICT_ASCII;
                end
            end
            default: n_verdict = ucls_pkg::VERDICT_INVALID;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_invalid <= ucls_pkg::ZERO_INVALID_RESET;
        end else if (i_cfg_wr_en) begin
            r_zero_invalid <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_seen      <= 1'b0;
            r_status    <= ST_SCAN;
            r_res_valid <= 1'b0;
        end else if (o_advance) begin
            r_res_valid <= w_fire && i_req.last_byte;
            if (w_fire) begin
                if (i_req.last_byte) begin
                    r_pend   <= '0;
                    r_seen   <= 1'b0;
                    r_status <= ST_SCAN;
                end else begin
                    r_pend   <= n_pend;
                    r_seen   <= n_seen;
                    r_status <= n_status;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && i_req.last_byte) begin
            r_verdict <= n_verdict;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_verdict   = r_verdict;

    `ASSERT_SYNC(a_pend_implies_seen, i_clk, i_rst_n, (r_pend != '0) |-> r_seen, "continuations owed without a multibyte lead")
    `ASSERT_SYNC(a_last_gives_result, i_clk, i_rst_n, (w_fire && i_req.last_byte) |=> r_res_valid, "final byte produced no verdict")
    `ASSERT_SYNC(a_last_clears_scan, i_clk, i_rst_n, (w_fire && i_req.last_byte) |=> (r_pend == '0 && !r_seen && r_status == ST_SCAN), "scan state not cleared after final byte")
    `ASSERT_SYNC(a_verdict_code, i_clk, i_rst_n, r_res_valid |-> (r_verdict == ucls_pkg::VERDICT_INVALID || r_verdict == ucls_pkg::VERDICT_ASCII || r_verdict == ucls_pkg::VERDICT_UTF8), "verdict code out of range")

endmodule

// ===== design/utf8_ascii_stream_classifier_unit.sv =====
// Top level of the UTF-8/ASCII buffer classifier.
//
// Bytes of one buffer arrive on i_byte, one per request, with last_byte set on
// the final byte. For each buffer exactly one request leaves on o_verdict:
// 0 invalid, 1 pure ASCII, 2 valid UTF-8 with multibyte characters.
// i_cfg_wr_en with i_cfg_wr_data writes zero_invalid; while it is set, a zero lead
// byte that is not the final byte marks the buffer invalid. Write it only while idle.
// Throughput is one byte per cycle unless the receiver stalls: the input register
// feeds the decode logic, which updates the scan state and loads the verdict register.
// A verdict appears on o_verdict once its final byte has passed the input register
// and the verdict register, and can be taken at the following edge.
// Bytes that are not final produce nothing and keep flowing.
// When the receiver stalls, the verdict register holds; one more byte waits in
// the input register and i_byte.ready then drops until the verdict is taken.
// Reset clears the scan state and both pipeline stages and sets zero_invalid
// to 1; the block accepts bytes as soon as reset is released.
module utf8_ascii_stream_classifier_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_wr_data,
    ucls_byte_if.sink        i_byte,
    ucls_verdict_if.source   o_verdict
);

    ucls_pkg::t_byte_req  w_req;
    logic                 w_advance;
    logic                 w_res_valid;
    logic [ucls_pkg::VERDICT_W-1:0] w_verdict;

    ucls_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (i_byte),
        .i_advance (w_advance),
        .o_req     (w_req)
    );

    ucls_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (w_req),
        .i_out_ready   (o_verdict.ready),
        .o_advance     (w_advance),
        .o_res_valid   (w_res_valid),
        .o_verdict     (w_verdict)
    );

    assign o_verdict.valid   = w_res_valid;
    assign o_verdict.verdict = w_verdict;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the UTF-8/ASCII buffer classifier with a scoreboard class.

class verdict_scoreboard;

    typedef enum logic [1:0] {
        SCAN_RUN,
        SCAN_STOPPED,
        SCAN_FAILED
    } scan_state_t;

    logic        zero_invalid;
    logic [1:0]  cont_owed;
    logic        saw_multibyte;
    scan_state_t scan_state;

    logic [ucls_pkg::VERDICT_W-1:0] verdicts_due[$];
    int mismatches;
    int bytes_seen;
    int verdict_tally[3];

    function new();
        zero_invalid  = ucls_pkg::ZERO_INVALID_RESET;
        cont_owed     = '0;
        saw_multibyte = 1'b0;
        scan_state    = SCAN_RUN;
        mismatches    = 0;
        bytes_seen    = 0;
        foreach (verdict_tally[i]) verdict_tally[i] = 0;
    endfunction

    task report(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Advances the scan by one accepted byte and queues a verdict on the final byte.
    function void note_byte(input logic [7:0] b, input logic is_last);
        logic [ucls_pkg::VERDICT_W-1:0] v;
        bytes_seen++;
        if (scan_state == SCAN_RUN) begin
            if (cont_owed != 0) begin
                if (b[7:6] == 2'b10) begin
                    cont_owed = cont_owed - 2'd1;
                end else begin
                    scan_state = SCAN_FAILED;
                end
            end else if (b == 8'h00) begin
                scan_state = (!is_last && zero_invalid) ? SCAN_FAILED : SCAN_STOPPED;
            end else if (b[7]) begin
                if (b < 8'hC0 || b > 8'hF4) begin
                    scan_state = SCAN_FAILED;
                end else begin
                    saw_multibyte = 1'b1;
                    if (b < 8'hE0) begin
                        cont_owed = 2'd1;
                    end else if (b < 8'hF0) begin
                        cont_owed = 2'd2;
                    end else begin
                        cont_owed = 2'd3;
                    end
                end
            end
        end
        if (is_last) begin
            if (scan_state == SCAN_FAILED || cont_owed != 0) begin
                v = ucls_pkg::VERDICT_INVALID;
            end else if (saw_multibyte) begin
                v = ucls_pkg::VERDICT_UTF8;
            end else begin
                v = ucls_pkg::VERDICT_ASCII;
            end
            verdicts_due = {verdicts_due, v};
            verdict_tally[v]++;
            cont_owed     = '0;
            saw_multibyte = 1'b0;
            scan_state    = SCAN_RUN;
        end
    endfunction

    task check_verdict(input logic [ucls_pkg::VERDICT_W-1:0] got);
        logic [ucls_pkg::VERDICT_W-1:0] want;
        if (verdicts_due.size() == 0) begin
            report($sformatf("verdict %0d with no buffer outstanding", got));
        end else begin
            want = verdicts_due.pop_front();
            if (got !== want) begin
                report($sformatf("verdict %0d, expected %0d", got, want));
            end
        end
    endtask

endclass

module tb_top;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 5;
    localparam int BYTES_PER_PHASE = 110;

    bit   i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic i_cfg_wr_data;

    ucls_byte_if    byte_bus();
    ucls_verdict_if verdict_bus();

    utf8_ascii_stream_classifier_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_byte        (byte_bus),
        .o_verdict     (verdict_bus)
    );

    verdict_scoreboard sb = new();

    bit         idle_on;
    int         quiet_cycles;
    int         buffers_sent;
    logic [7:0] line_bytes[$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Checks verdicts, follows the predictor and watches for a stuck handshake.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (verdict_bus.valid && verdict_bus.ready) begin
                sb.check_verdict(verdict_bus.verdict);
            end
            if (byte_bus.valid && byte_bus.ready) begin
                sb.note_byte(byte_bus.data_byte, byte_bus.last_byte);
            end
        end
        if ((byte_bus.valid && byte_bus.ready) || (verdict_bus.valid && verdict_bus.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL utf8_ascii_stream_classifier_unit");
            $finish;
        end
    end

    // Receiver side: stalls in random bursts while idling is enabled.
    initial begin : verdict_sink
        int stall;
        stall = 0;
        verdict_bus.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                verdict_bus.ready <= 1'b0;
                stall--;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                verdict_bus.ready <= 1'b0;
                stall = $urandom_range(1, 9) - 1;
            end else begin
                verdict_bus.ready <= 1'b1;
            end
        end
    end

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    // Random buffer: mostly well-formed characters, some corrupted, truncated or pure noise.
    function automatic void build_buffer();
        int kind;
        int n;
        int idx;
        line_bytes.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            n = $urandom_range(1, 8);
            repeat (n) line_bytes = {line_bytes, 8'($urandom_range(0, 255))};
        end else begin
            n = $urandom_range(1, 8);
            repeat (n) begin
                case ($urandom_range(0, 3))
                    0: begin
                        if ($urandom_range(0, 15) == 0) begin
                            line_bytes = {line_bytes, 8'h00};
                        end else begin
                            line_bytes = {line_bytes, 8'($urandom_range(1, 8'h7F))};
                        end
                    end
                    1: begin
                        line_bytes = {line_bytes, 8'($urandom_range(8'hC0, 8'hDF))};
                        line_bytes = {line_bytes, cont_byte()};
                    end
                    2: begin
                        line_bytes = {line_bytes, 8'($urandom_range(8'hE0, 8'hEF))};
                        repeat (2) line_bytes = {line_bytes, cont_byte()};
                    end
                    default: begin
                        line_bytes = {line_bytes, 8'($urandom_range(8'hF0, 8'hF4))};
                        repeat (3) line_bytes = {line_bytes, cont_byte()};
                    end
                endcase
            end
            if (kind == 1) begin
                idx = $urandom_range(0, line_bytes.size() - 1);
                line_bytes[idx] = 8'($urandom_range(0, 255));
            end else if (kind == 2 && line_bytes.size() > 1) begin
                n = $urandom_range(1, line_bytes.size() - 1);
                repeat (n) void'(line_bytes.pop_back());
            end
        end
    endfunction

    // Sends one byte request; called and returns at a falling edge.
    task automatic push_byte(input logic [7:0] b, input logic is_last);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            byte_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        byte_bus.valid     <= 1'b1;
        byte_bus.data_byte <= b;
        byte_bus.last_byte <= is_last;
        @(posedge i_clk);
        while (!byte_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_buffer();
        foreach (line_bytes[i]) begin
            push_byte(line_bytes[i], i == line_bytes.size() - 1);
        end
        buffers_sent++;
    endtask

    // Holds the sender off until every buffer has its verdict and the pipeline is empty.
    task automatic wait_drained();
        byte_bus.valid <= 1'b0;
        while (sb.verdicts_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_zero_invalid(input logic value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        sb.zero_invalid = value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin : stimulus
        logic zi_plan[RANDOM_PHASES];
        zi_plan = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        i_rst_n              = 1'b0;
        i_cfg_wr_en          = 1'b0;
        i_cfg_wr_data        = 1'b0;
        byte_bus.valid       = 1'b0;
        byte_bus.data_byte   = '0;
        byte_bus.last_byte   = 1'b0;
        idle_on              = 1'b1;
        quiet_cycles         = 0;
        buffers_sent         = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed buffers with zero_invalid at its reset value.
        line_bytes = '{8'h41, 8'h7F};              send_buffer();
        line_bytes = '{8'hC0, 8'h80};              send_buffer();
        line_bytes = '{8'hE0, 8'h80, 8'hBF};       send_buffer();
        line_bytes = '{8'hF4, 8'hBF, 8'hBF, 8'hBF}; send_buffer();
        line_bytes = '{8'h80};                     send_buffer();
        line_bytes = '{8'hF5, 8'h41};              send_buffer();
        line_bytes = '{8'hC2, 8'h41};              send_buffer();
        line_bytes = '{8'hE2, 8'h82};              send_buffer();
        line_bytes = '{8'h41, 8'h00, 8'hFF};       send_buffer();
        line_bytes = '{8'h00};                     send_buffer();
        wait_drained();
        // A zero lead byte only stops the scan once zero_invalid is cleared.
        write_zero_invalid(1'b0);
        line_bytes = '{8'hC3, 8'hA9, 8'h00, 8'hFF}; send_buffer();
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_zero_invalid(zi_plan[p]);
            while (sb.bytes_seen < 26 + BYTES_PER_PHASE * (p + 1)) begin
                idle_on = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
                build_buffer();
                send_buffer();
            end
            wait_drained();
        end

        idle_on = 1'b0;
        repeat (6) @(negedge i_clk);
        $display("Covered %0d bytes in %0d buffers over both zero_invalid settings.",
                 sb.bytes_seen, buffers_sent);
        $display("Verdicts: %0d invalid, %0d ASCII, %0d UTF-8; %0d mismatches.",
                 sb.verdict_tally[ucls_pkg::VERDICT_INVALID],
                 sb.verdict_tally[ucls_pkg::VERDICT_ASCII],
                 sb.verdict_tally[ucls_pkg::VERDICT_UTF8], sb.mismatches);
        if (sb.mismatches == 0 && sb.verdicts_due.size() == 0) begin
            $display("PASS utf8_ascii_stream_classifier_unit");
        end else begin
            $display("FAIL utf8_ascii_stream_classifier_unit");
        end
        $finish;
    end

endmodule
